// File: hw/rtl/soundex_word_encoder_top_defines.svh
// Assertion macros used by the encoder top-level RTL.
`ifndef SOUNDEX_WORD_ENCODER_TOP_DEFINES_SVH
`define SOUNDEX_WORD_ENCODER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SDX_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define SDX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/sdx_pkg.sv
`default_nettype none
package sdx_pkg;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [6:0] LETTER_BASE = 7'h61;
	localparam logic [2:0] DIGIT_NONE = 3'd7;
	localparam logic [2:0] DIGIT_VOWEL = 3'd0;
	localparam int MAX_DIGITS = 3;

	typedef logic [2:0] digit_t;

	typedef struct packed {
		logic is_letter;
		logic [4:0] index;
		digit_t digit;
	} sdx_char_t;

	typedef struct packed {
		logic [6:0] lead_letter;
		digit_t lead_digit;
		digit_t digit_a;
		digit_t digit_b;
		digit_t digit_c;
		logic [9:0] digits_value;
		logic no_letter;
	} sdx_result_t;

	// Standard Soundex digit per letter index, a = 0.
	function automatic digit_t letter_digit(input logic [4:0] idx);
		digit_t d;
		case (idx)
			5'd1, 5'd5, 5'd15, 5'd21: d = 3'd1;
			5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: d = 3'd2;
			5'd3, 5'd19: d = 3'd3;
			5'd11: d = 3'd4;
			5'd12, 5'd13: d = 3'd5;
			5'd17: d = 3'd6;
			default: d = DIGIT_VOWEL;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/soundex_word_encoder_top.sv
// Soundex word encoder, one character per cycle while no final character waits on a stalled result.
// A word's last character is held in the input register; the result register loads when it
// leaves that register, and out_valid is registered with that load.
// Throughput: one character per cycle; only a final character waits while a result stalls.
// Reset: arst_n clears the word state and both valid flags; the code state returns to empty.
`default_nettype none
`include "soundex_word_encoder_top_defines.svh"
module soundex_word_encoder_top
	import sdx_pkg::*;
#(
	parameter int CODE_LENGTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] char_code,
	input wire logic end_of_word,
	output logic out_valid,
	input wire logic out_ready,
	output logic [6:0] lead_letter,
	output logic [2:0] lead_digit,
	output logic [2:0] digit_a,
	output logic [2:0] digit_b,
	output logic [2:0] digit_c,
	output logic [9:0] digits_value,
	output logic no_letter
);

	logic valid_s1;
	logic [7:0] char_s1;
	logic eow_s1;
	logic fire_s1;
	logic valid_s2;
	sdx_result_t res_s2;
	sdx_char_t info;
	sdx_result_t result;

	// a final character needs room in the result register
	assign fire_s1 = valid_s1 && (!eow_s1 || !valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			eow_s1 <= end_of_word;
		end
	end

	sdx_char_map u_map (
		.char_code(char_s1),
		.info(info)
	);

	sdx_accum #(
		.CODE_LENGTH(CODE_LENGTH)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.step(fire_s1),
		.last(eow_s1),
		.info(info),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1 && eow_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && eow_s1) begin
			res_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign lead_letter = res_s2.lead_letter;
	assign lead_digit = res_s2.lead_digit;
	assign digit_a = res_s2.digit_a;
	assign digit_b = res_s2.digit_b;
	assign digit_c = res_s2.digit_c;
	assign digits_value = res_s2.digits_value;
	assign no_letter = res_s2.no_letter;

	`SDX_ASSERT_SAME(a_stall_cause, !in_ready,
		valid_s1 && eow_s1 && valid_s2 && !out_ready, "input stalled without cause")
	`SDX_ASSERT_NEXT(a_result_load, fire_s1 && eow_s1, out_valid,
		"final character did not produce a result")
	`SDX_ASSERT_SAME(a_empty_word, out_valid && no_letter,
		lead_letter == 7'd0 && digits_value == 10'd0, "empty word carries a code")
	`SDX_ASSERT_SAME(a_letter_range, out_valid && !no_letter,
		lead_letter >= 7'h61 && lead_letter <= 7'h7A, "lead letter out of range")

endmodule
`default_nettype wire

// File: hw/rtl/sdx_char_map.sv
`default_nettype none
module sdx_char_map
	import sdx_pkg::*;
(
	input wire logic [7:0] char_code,
	output sdx_char_t info
);

	logic is_upper;
	logic is_lower;
	logic [7:0] offset;

	always_comb begin
		is_upper = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_Z);
		is_lower = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_Z);
		offset = is_lower ? (char_code - CHAR_LOWER_A) : (char_code - CHAR_UPPER_A);
		info.is_letter = is_upper || is_lower;
		info.index = is_upper || is_lower ? offset[4:0] : 5'd0;
		info.digit = letter_digit(info.index);
	end

endmodule
`default_nettype wire

// File: hw/rtl/sdx_accum.sv
`default_nettype none
module sdx_accum
	import sdx_pkg::*;
#(
	parameter int CODE_LENGTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic last,
	input wire sdx_char_t info,
	output sdx_result_t result
);

	localparam int DIGIT_LIMIT_INT = (CODE_LENGTH - 1 > MAX_DIGITS) ? MAX_DIGITS :
		((CODE_LENGTH > 1) ? CODE_LENGTH - 1 : 0);
	localparam logic [1:0] DIGIT_LIMIT = DIGIT_LIMIT_INT[1:0];

	logic seen_q, seen_n;
	logic [4:0] lead_q, lead_n;
	digit_t prior_q, prior_n;
	logic [1:0] count_q, count_n;
	digit_t digits_q [MAX_DIGITS];
	digit_t digits_n [MAX_DIGITS];

	always_comb begin
		seen_n = seen_q;
		lead_n = lead_q;
		prior_n = prior_q;
		count_n = count_q;
		digits_n = digits_q;
		if (info.is_letter) begin
			if (!seen_q) begin
				seen_n = 1'b1;
				lead_n = info.index;
			end else if (count_q < DIGIT_LIMIT) begin
				// vowels neither append nor clear the previous digit
				if (info.digit != DIGIT_VOWEL && info.digit != prior_q) begin
					digits_n[count_q] = info.digit;
					count_n = count_q + 2'd1;
					prior_n = info.digit;
				end
			end
		end
	end

	always_comb begin
		if (seen_n) begin
			result.lead_letter = LETTER_BASE + {2'b00, lead_n};
			result.lead_digit = letter_digit(lead_n);
			result.digit_a = digits_n[0];
			result.digit_b = digits_n[1];
			result.digit_c = digits_n[2];
			result.digits_value = {7'd0, digits_n[0]} * 10'd100
				+ {7'd0, digits_n[1]} * 10'd10 + {7'd0, digits_n[2]};
			result.no_letter = 1'b0;
		end else begin
			result = '0;
			result.no_letter = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			lead_q <= 5'd0;
			prior_q <= DIGIT_NONE;
			count_q <= 2'd0;
			for (int i = 0; i < MAX_DIGITS; i++) digits_q[i] <= DIGIT_VOWEL;
		end else if (step) begin
			if (last) begin
				// clear for the next word
				seen_q <= 1'b0;
				lead_q <= 5'd0;
				prior_q <= DIGIT_NONE;
				count_q <= 2'd0;
				for (int i = 0; i < MAX_DIGITS; i++) digits_q[i] <= DIGIT_VOWEL;
			end else begin
				seen_q <= seen_n;
				lead_q <= lead_n;
				prior_q <= prior_n;
				count_q <= count_n;
				digits_q <= digits_n;
			end
		end
	end

endmodule
`default_nettype wire
